// ----- rtl/opwf_pkg.sv -----
// Package for the OLED page write framer.
// Holds the shared types, register indexes and command byte constants.
// No dependencies.
`timescale 1ns / 1ps

package opwf_pkg;

    localparam logic [7:0] MAX_BYTES_PER_PAGE = 8'd128;
    localparam int unsigned CMDQ_DEPTH = 4;

    // Command bytes of the page addressing header
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
    localparam logic [7:0] CMD_END_PAGE  = 8'h00;
    localparam logic [7:0] CMD_COL_BASE  = 8'h10;
    localparam logic [3:0] NIBBLE_MASK   = 4'hF;

    // Register indexes (byte address divided by four)
    localparam logic [1:0] REG_START_COLUMN   = 2'd0;
    localparam logic [1:0] REG_BYTES_PER_PAGE = 2'd1;
    localparam logic [1:0] REG_START_PAGE     = 2'd2;
    localparam logic [1:0] REG_STOP_PAGE      = 2'd3;

    typedef struct packed {
        logic [7:0] start_column;
        logic [7:0] bytes_per_page;
        logic [3:0] start_page;
        logic [3:0] stop_page;
    } t_cfg;

    // One classified word passed from the front to the back
    typedef struct packed {
        logic [7:0] pixel;
        logic       hdr;
        logic [3:0] page;
        logic       frame_done;
    } t_cmd;

    typedef struct packed {
        logic [7:0] serial_byte;
        logic       is_data;
        logic       last;
        logic       frame_done;
    } t_res;

    typedef enum logic [2:0] {
        ST_PAGE_CMD,
        ST_PAGE_NUM,
        ST_END_PAGE,
        ST_COL_CMD,
        ST_COL_LO,
        ST_COL_HI,
        ST_DATA
    } t_step;

endpackage

// ----- rtl/opwf_front.sv -----
// Front end of the OLED page write framer: accepts pixel words, tracks the
// column and page position, and classifies each word for the back end.
// Depends on opwf_pkg.
`timescale 1ns / 1ps

module opwf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  opwf_pkg::t_cfg i_cfg,
    input  logic           push,
    output logic           full,
    input  logic [7:0]     i_pixel_byte,
    input  logic           i_q_full,
    output logic           o_q_push,
    output opwf_pkg::t_cmd o_q_cmd
);
    import opwf_pkg::*;

    logic [3:0] r_page_off, n_page_off;
    logic [7:0] r_col, n_col;
    logic [7:0] limit;
    logic [3:0] stop_eff;
    logic [3:0] last_off;
    logic       page_end;
    logic       frame_end;
    logic       accept;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;

    always_comb begin
        if (i_cfg.bytes_per_page == 8'd0) begin
            limit = 8'd1;
        end else if (i_cfg.bytes_per_page > MAX_BYTES_PER_PAGE) begin
            limit = MAX_BYTES_PER_PAGE;
        end else begin
            limit = i_cfg.bytes_per_page;
        end
        stop_eff  = (i_cfg.stop_page < i_cfg.start_page) ? i_cfg.start_page : i_cfg.stop_page;
        last_off  = stop_eff - i_cfg.start_page;
        page_end  = ({1'b0, r_col} + 9'd1) >= {1'b0, limit};
        frame_end = page_end && (r_page_off >= last_off);
    end

    always_comb begin
        n_page_off = r_page_off;
        n_col      = r_col;
        if (accept) begin
            if (page_end) begin
                n_col      = 8'd0;
                n_page_off = frame_end ? 4'd0 : r_page_off + 4'd1;
            end else begin
                n_col = r_col + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_off <= 4'd0;
            r_col      <= 8'd0;
        end else begin
            r_page_off <= n_page_off;
            r_col      <= n_col;
        end
    end

    assign o_q_push           = accept;
    assign o_q_cmd.pixel      = i_pixel_byte;
    assign o_q_cmd.hdr        = (r_col == 8'd0);
    assign o_q_cmd.page       = i_cfg.start_page + r_page_off;
    assign o_q_cmd.frame_done = frame_end;

endmodule

// ----- rtl/opwf_cmd_queue.sv -----
// Short queue of classified words between the front and the back end.
// Depends on opwf_pkg.
`timescale 1ns / 1ps

module opwf_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  opwf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output opwf_pkg::t_cmd o_head,
    output logic           o_empty
);
    import opwf_pkg::*;

    localparam int unsigned PW = $clog2(CMDQ_DEPTH);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == PW'(0) + (PW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/opwf_back.sv -----
// Back end of the OLED page write framer: expands each classified word into
// the data byte, after the header command bytes for a page start, into a two-entry
// result queue. Depends on opwf_pkg.
`timescale 1ns / 1ps

module opwf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_start_column,
    input  opwf_pkg::t_cmd i_head,
    input  logic           i_head_empty,
    output logic           o_head_pop,
    output logic           empty,
    input  logic           pop,
    output opwf_pkg::t_res o_res
);
    import opwf_pkg::*;

    t_step r_step, n_step;
    t_step eff_step;
    t_res  r_ob [2];
    logic  r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic  out_full;
    logic  emit;
    logic  take;
    t_res  res;

    assign out_full = (r_ocnt == 2'd2);
    assign empty    = (r_ocnt == 2'd0);
    assign emit     = !i_head_empty && !out_full;
    assign take     = pop && !empty;
    assign o_res    = r_ob[r_orp];

    // A word without a header goes straight to its data byte.
    assign eff_step = (r_step == ST_PAGE_CMD && !i_head.hdr) ? ST_DATA : r_step;

    always_comb begin
        n_step = r_step;
        if (emit) begin
            unique case (eff_step)
                ST_PAGE_CMD: n_step = ST_PAGE_NUM;
                ST_PAGE_NUM: n_step = ST_END_PAGE;
                ST_END_PAGE: n_step = ST_COL_CMD;
                ST_COL_CMD:  n_step = ST_COL_LO;
                ST_COL_LO:   n_step = ST_COL_HI;
                ST_COL_HI:   n_step = ST_DATA;
                ST_DATA:     n_step = ST_PAGE_CMD;
                default:     n_step = ST_PAGE_CMD;
            endcase
        end
    end

    always_comb begin
        res.is_data    = 1'b0;
        res.last       = 1'b0;
        res.frame_done = 1'b0;
        o_head_pop     = 1'b0;
        unique case (eff_step)
            ST_PAGE_CMD: res.serial_byte = CMD_PAGE_ADDR;
            ST_PAGE_NUM: res.serial_byte = {4'd0, i_head.page};
            ST_END_PAGE: res.serial_byte = CMD_END_PAGE;
            ST_COL_CMD:  res.serial_byte = CMD_COL_BASE;
            ST_COL_LO:   res.serial_byte = {4'd0, i_start_column[3:0] & NIBBLE_MASK};
            ST_COL_HI:   res.serial_byte = CMD_COL_BASE | {4'd0, i_start_column[7:4]};
            ST_DATA: begin
                res.serial_byte = i_head.pixel;
                res.is_data     = 1'b1;
                res.last        = 1'b1;
                res.frame_done  = i_head.frame_done;
                o_head_pop      = emit;
            end
            default: res.serial_byte = CMD_END_PAGE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ob[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_PAGE_CMD;
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            r_step <= n_step;
            if (emit) begin
                r_owp <= !r_owp;
            end
            if (take) begin
                r_orp <= !r_orp;
            end
            case ({emit, take})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

endmodule

// ----- rtl/oled_page_write_framer_unit.sv -----
// Top level of the OLED page write framer: configuration registers, front end,
// word queue and back end. Depends on opwf_pkg and the opwf_* modules.
// Throughput: one word a cycle for data-only words while the result queue has room;
// a page start word gives seven result words, one at a time from the back end output.
// An accepted word is registered in the word queue, then in the result queue, before its
// results are out; a page start word's data byte follows its six header bytes.
// Reset: synchronous, active low; position state clears and registers take reset values.
`timescale 1ns / 1ps

module oled_page_write_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_pixel_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_serial_byte,
    output logic        o_is_data,
    output logic        o_last,
    output logic        o_frame_done
);
    import opwf_pkg::*;

    t_cfg r_cfg;
    t_cmd q_in_cmd, q_head;
    t_res res;
    logic q_push, q_full, q_pop, q_empty;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_column   <= 8'd0;
            r_cfg.bytes_per_page <= MAX_BYTES_PER_PAGE;
            r_cfg.start_page     <= 4'd0;
            r_cfg.stop_page      <= 4'd3;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_START_COLUMN:   r_cfg.start_column   <= pwdata[7:0];
                REG_BYTES_PER_PAGE: r_cfg.bytes_per_page <= pwdata[7:0];
                REG_START_PAGE:     r_cfg.start_page     <= pwdata[3:0];
                REG_STOP_PAGE:      r_cfg.stop_page      <= pwdata[3:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START_COLUMN:   prdata = {24'd0, r_cfg.start_column};
            REG_BYTES_PER_PAGE: prdata = {24'd0, r_cfg.bytes_per_page};
            REG_START_PAGE:     prdata = {28'd0, r_cfg.start_page};
            REG_STOP_PAGE:      prdata = {28'd0, r_cfg.stop_page};
            default:            prdata = 32'd0;
        endcase
    end

    opwf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .push         (push),
        .full         (full),
        .i_pixel_byte (i_pixel_byte),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in_cmd)
    );

    opwf_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    opwf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_column (r_cfg.start_column),
        .i_head         (q_head),
        .i_head_empty   (q_empty),
        .o_head_pop     (q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_res          (res)
    );

    assign o_serial_byte = res.serial_byte;
    assign o_is_data     = res.is_data;
    assign o_last        = res.last;
    assign o_frame_done  = res.frame_done;

endmodule
